// File: rtl/core/sbhi_pkg.sv
// ----------------------------------------------------------------------------
// sbhi_pkg: shared definitions for the string hash bucket index unit
// Field widths, hash constants, register reset value and sequencer states.
// ----------------------------------------------------------------------------
package sbhi_pkg;

    // Field widths
    localparam int KEY_W   = 8;
    localparam int CODE_W  = 31;
    localparam int IDX_W   = 24;
    localparam int TS_W    = 25;
    localparam int SUM_W   = 32;
    localparam int SHIFT_W = 5;
    localparam int CNT_W   = 5;
    localparam int OUT_W   = 56;

    // Hash constants
    localparam logic [SHIFT_W-1:0] START_SHIFT = 5'd22;
    localparam logic [5:0]         SHIFT_STEP  = 6'd7;
    localparam logic [5:0]         SHIFT_WRAP  = 6'd24;
    localparam logic [5:0]         SHIFT_WRAP2 = 6'd48;
    localparam logic [4:0]         LOW5_MASK   = 5'h1F;

    // Register reset value
    localparam logic [TS_W-1:0] TS_RESET = 25'd4096;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

// File: rtl/core/string_hash_bucket_index_unit.sv
// ----------------------------------------------------------------------------
// string_hash_bucket_index_unit: hash a key string and find its bucket
// Sums shifted key bytes into a 32-bit hash, folds it to a 31-bit code and
// reduces the code modulo (table_size - 1) with a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Key bytes arrive one per beat on the s_axis channel, tlast on the final
//   byte. Non-final bytes are taken one per cycle, back to back.
//   A final byte starts the remainder sequence: the single 33-bit adder that
//   sums the bytes is then reused as the trial subtractor of a restoring
//   divider, one code bit per cycle. The done state then moves the result
//   into the output register once that register is free.
//   s_axis_tready is low during that sequence and while a finished result waits.
//   The result beat on m_axis holds hash code and bucket index. While it
//   waits for m_axis_tready the next key's bytes are still taken; a further
//   result waits in the sequencer until the output register is free.
//   The user must write table_size via i_cfg_wr_en / i_cfg_wr_data only while
//   idle, not checked by the block; a size below two gives bucket index zero.
//   Synchronous active-low reset sets table_size to 4096, clears the hash
//   state and empties the output register.
// ----------------------------------------------------------------------------
module string_hash_bucket_index_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_wr_en,
    input  logic [sbhi_pkg::TS_W-1:0] i_cfg_wr_data,  // table_size
    // key byte stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [sbhi_pkg::KEY_W-1:0] s_axis_tdata,  // [7:0] key_byte
    input  logic                      s_axis_tlast,   // last_byte
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [sbhi_pkg::OUT_W-1:0] m_axis_tdata   // [30:0] hash_code,
                                                      // [54:31] bucket_index,
                                                      // [55] zero
);
    import sbhi_pkg::*;

    t_state               r_state, n_state;
    logic [TS_W-1:0]      r_ts;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [SHIFT_W-1:0]   r_shift, n_shift;
    logic                 r_first, n_first;
    logic [CODE_W-1:0]    r_code, n_code;
    logic [CODE_W-1:0]    r_quo, n_quo;
    logic [TS_W-1:0]      r_rem, n_rem;
    logic [TS_W-1:0]      r_div, n_div;
    logic                 r_div_zero, n_div_zero;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [CODE_W-1:0]    r_out_code, n_out_code;
    logic [IDX_W-1:0]     r_out_idx, n_out_idx;

    logic                 w_accept;
    logic                 w_out_free;
    logic [5:0]           w_sh_raw;
    logic [5:0]           w_sh_mod;
    logic [SHIFT_W-1:0]   w_shift;
    logic [SUM_W-1:0]     w_addend;
    logic [TS_W:0]        w_trial;
    logic [SUM_W-1:0]     w_op_a, w_op_b;
    logic                 w_cin;
    logic [SUM_W:0]       w_add;
    logic [CODE_W-1:0]    w_code;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Advance the shift amount, wrapping modulo 24 by compare and subtract
    always_comb begin
        w_sh_raw = {1'b0, r_shift} + SHIFT_STEP + {1'b0, s_axis_tdata[4:0] & LOW5_MASK};
        if (w_sh_raw >= SHIFT_WRAP2) begin
            w_sh_mod = w_sh_raw - SHIFT_WRAP2;
        end else if (w_sh_raw >= SHIFT_WRAP) begin
            w_sh_mod = w_sh_raw - SHIFT_WRAP;
        end else begin
            w_sh_mod = w_sh_raw;
        end
        w_shift  = r_first ? r_shift : w_sh_mod[SHIFT_W-1:0];
        w_addend = {{(SUM_W-KEY_W){1'b0}}, s_axis_tdata} << w_shift;
    end

    // Shared adder: byte accumulation when idle, trial subtract when dividing
    always_comb begin
        w_trial = {r_rem, r_quo[CODE_W-1]};
        if (r_state == ST_DIV) begin
            w_op_a = {{(SUM_W-TS_W-1){1'b0}}, w_trial};
            w_op_b = ~{{(SUM_W-TS_W){1'b0}}, r_div};
            w_cin  = 1'b1;
        end else begin
            w_op_a = r_sum;
            w_op_b = w_addend;
            w_cin  = 1'b0;
        end
        w_add = {1'b0, w_op_a} + {1'b0, w_op_b} + {{SUM_W{1'b0}}, w_cin};
    end

    // Fold the negative sum: -(x + 1) is the bitwise inverse of x
    assign w_code = w_add[SUM_W-1] ? ~w_add[CODE_W-1:0] : w_add[CODE_W-1:0];

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_shift     = r_shift;
        n_first     = r_first;
        n_code      = r_code;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_div_zero  = r_div_zero;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_code  = r_out_code;
        n_out_idx   = r_out_idx;

        // drop the result beat once taken
        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tlast) begin
                        // close the key and start the remainder sequence
                        n_code     = w_code;
                        n_quo      = w_code;
                        n_rem      = '0;
                        n_div      = r_ts - TS_W'(1);
                        n_div_zero = (r_ts < TS_W'(2));
                        n_cnt      = '0;
                        n_sum      = '0;
                        n_shift    = START_SHIFT;
                        n_first    = 1'b1;
                        n_state    = ST_DIV;
                    end else begin
                        n_sum   = w_add[SUM_W-1:0];
                        n_shift = w_shift;
                        n_first = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                // one restoring step per cycle
                n_quo = {r_quo[CODE_W-2:0], 1'b0};
                if (w_add[SUM_W]) begin
                    n_rem = w_add[TS_W-1:0];
                end else begin
                    n_rem = w_trial[TS_W-1:0];
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CODE_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_code;
                    n_out_idx   = r_div_zero ? '0 : r_rem[IDX_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ts        <= TS_RESET;
            r_sum       <= '0;
            r_shift     <= START_SHIFT;
            r_first     <= 1'b1;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) begin
                r_ts <= i_cfg_wr_data;
            end
            r_sum       <= n_sum;
            r_shift     <= n_shift;
            r_first     <= n_first;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_div_zero <= n_div_zero;
        r_out_code <= n_out_code;
        r_out_idx  <= n_out_idx;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_idx, r_out_code};

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt <= CNT_W'(CODE_W - 1)))
        else $error("divider step count out of range");

    a_last_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> (r_state == ST_DIV && r_cnt == '0 && r_first))
        else $error("final byte did not start the remainder sequence");

    a_mid_clears_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !s_axis_tlast) |=> (!r_first && r_state == ST_IDLE))
        else $error("non-final byte did not continue the key");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished result not moved to the output register");

endmodule
